FILE: hdl/ole_pkg.sv
// Shared codes, field widths and control structures of the ordered list engine.
package ole_pkg;

  // Field widths of the input and result words.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned COUNT_W  = 10;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_APPEND    = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_AT = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_VAL = 3'd3;
  localparam logic [OP_W-1:0] OP_FIND      = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // The match scan looks at this many cells per cycle.
  localparam int unsigned SCAN_LANES  = 8;
  localparam int unsigned SCAN_LANE_W = 3;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp;  // register the match flag against the broadcast word
    logic ins;  // open a gap at the position and write the word there
    logic del;  // close the gap at the position
  } cell_cmd_t;

  // Result of the match scan.
  typedef struct packed {
    logic done;  // one-cycle pulse when the scan has finished
    logic hit;   // a match was found, held until the next start
  } scan_res_t;

endpackage

FILE: hdl/ole_cell.sv
// One list position: holds an entry, compares it and shifts to or from its neighbours.
module ole_cell #(
  parameter int unsigned DEPTH      = 512,
  parameter int unsigned ITEM_WIDTH = 32,
  parameter int unsigned IDX        = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ole_pkg::cell_cmd_t           cmd_i,
  input  logic [$clog2(DEPTH)-1:0]     pos_i,
  input  logic [$clog2(DEPTH+1)-1:0]   len_i,
  input  logic [ITEM_WIDTH-1:0]        val_i,
  input  logic [ITEM_WIDTH-1:0]        prev_i,
  input  logic [ITEM_WIDTH-1:0]        next_i,
  output logic [ITEM_WIDTH-1:0]        entry_o,
  output logic                         match_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH+1);

  logic [ITEM_WIDTH-1:0] entry_q, entry_d;
  logic                  match_q;
  logic                  at_pos, after_pos, below_len, upto_len;

  assign at_pos    = (PW'(IDX) == pos_i);
  assign after_pos = (PW'(IDX) > pos_i);
  assign below_len = (LW'(IDX) < len_i);
  assign upto_len  = (LW'(IDX) <= len_i);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (at_pos) begin
        entry_d = val_i;
      end else if (after_pos && upto_len) begin
        entry_d = prev_i;
      end
    end else if (cmd_i.del) begin
      // Cells past the old tail take stale words, which are never read.
      if (at_pos || after_pos) begin
        entry_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (cmd_i.cmp) begin
      match_q <= below_len && (entry_q == val_i);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

FILE: hdl/ole_scan.sv
// First-match search over the cell match flags, a few cells per cycle.
module ole_scan #(
  parameter int unsigned DEPTH = 512
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [$clog2(DEPTH+1)-1:0] len_i,
  input  logic [DEPTH-1:0]           match_i,
  output ole_pkg::scan_res_t         res_o,
  output logic [$clog2(DEPTH)-1:0]   pos_o
);

  localparam int unsigned LANES  = ole_pkg::SCAN_LANES;
  localparam int unsigned LANEW  = ole_pkg::SCAN_LANE_W;
  localparam int unsigned NCHUNK = (DEPTH + LANES - 1) / LANES;
  localparam int unsigned CNTW   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned PADW   = NCHUNK * LANES;
  localparam int unsigned PW     = $clog2(DEPTH);
  localparam int unsigned LW     = $clog2(DEPTH+1);

  logic [PADW-1:0]  match_pad;
  logic [LANES-1:0] chunk_w [NCHUNK];
  logic [LANES-1:0] chunk;
  logic [LANEW-1:0] lane_idx;
  logic             chunk_hit, scan_done;

  logic [CNTW-1:0]  cnt_q, last_q;
  logic             active_q, done_q, hit_q;
  logic [PW-1:0]    pos_q;

  assign match_pad = PADW'(match_i);

  always_comb begin
    for (int c = 0; c < NCHUNK; c++) begin
      chunk_w[c] = match_pad[c*LANES +: LANES];
    end
  end

  assign chunk     = chunk_w[cnt_q];
  assign chunk_hit = |chunk;

  always_comb begin
    lane_idx = '0;
    for (int l = LANES - 1; l >= 0; l--) begin
      if (chunk[l]) begin
        lane_idx = LANEW'(l);
      end
    end
  end

  assign scan_done = active_q && (chunk_hit || (cnt_q == last_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      last_q   <= '0;
      active_q <= 1'b0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      done_q <= scan_done;
      if (start_i) begin
        cnt_q    <= '0;
        active_q <= 1'b1;
        hit_q    <= 1'b0;
        if (len_i == '0) begin
          last_q <= '0;
        end else begin
          last_q <= CNTW'((len_i - LW'(1)) >> LANEW);
        end
      end else if (scan_done) begin
        active_q <= 1'b0;
        hit_q    <= chunk_hit;
      end else if (active_q) begin
        cnt_q <= cnt_q + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_done) begin
      pos_q <= PW'({cnt_q, lane_idx});
    end
  end

  assign res_o.done = done_q;
  assign res_o.hit  = hit_q;
  assign pos_o      = pos_q;

endmodule

FILE: hdl/ordered_list_engine.sv
// Top level of the ordered list engine: control sequencer, cell chain and result register.
//
// The engine keeps an ordered list of up to DEPTH item words and its length.
// Each input word on the in_ channel carries an operation (append, insert at
// index, remove at index, remove by value, find, clear), an index and an item
// word; each yields exactly one result word on the out_ channel with a status,
// a found flag, the first matching position and the count after the operation.
// A word moves on a channel at a rising edge where valid is high and stall low.
// Every list position is a cell in a chain; inserts and removals shift the cells
// from the affected position onwards towards or away from their neighbours together.
// Append, insert, remove at index and clear go straight to the apply step, which
// loads the result once the output register is free. Find and remove by value
// compare every cell at once and then search the match flags 8 cells per cycle,
// up to the first group with a match or the group holding the last entry, before
// the apply step. in_stall_o is high from acceptance until the result is loaded,
// so a new input word is taken only after the previous result has been loaded.
// A result waiting under out_stall_i does not block the next input word; its
// update is held back until the output register is free.
// Reset empties the list and the output register; the entry storage itself is
// not cleared, and only positions below the length are ever read.
module ordered_list_engine #(
  parameter int unsigned DEPTH      = 512,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ole_pkg::OP_W-1:0]       op_i,
  input  logic [ole_pkg::INDEX_W-1:0]    index_i,
  input  logic [ole_pkg::VALUE_W-1:0]    value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ole_pkg::STATUS_W-1:0]   status_o,
  output logic                           found_o,
  output logic [ole_pkg::POS_W-1:0]      position_o,
  output logic [ole_pkg::COUNT_W-1:0]    count_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH+1);
  // Common width for comparing the index field against the length.
  localparam int unsigned CW = (LW > ole_pkg::INDEX_W) ? LW : ole_pkg::INDEX_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [ole_pkg::OP_W-1:0]      op_q;
  logic [ole_pkg::INDEX_W-1:0]   idx_q;
  logic [ITEM_WIDTH-1:0]         val_q;
  logic [LW-1:0]                 len_q, len_d;

  logic                          out_valid_q;
  logic [ole_pkg::STATUS_W-1:0]  status_q, status_d;
  logic                          found_q, found_d;
  logic [ole_pkg::POS_W-1:0]     position_q;
  logic [ole_pkg::COUNT_W-1:0]   count_q;
  logic [PW-1:0]                 pos_res;

  logic                          in_fire, out_free, apply_fire;
  logic                          is_search, full;
  logic                          do_ins, do_del;
  logic [PW-1:0]                 cell_pos;
  logic [CW-1:0]                 idx_ext, len_ext;

  ole_pkg::cell_cmd_t            cmd;
  ole_pkg::scan_res_t            scan_res;
  logic [PW-1:0]                 scan_pos;

  logic [ITEM_WIDTH-1:0]         entry_w [DEPTH];
  logic [ITEM_WIDTH-1:0]         prev_w  [DEPTH];
  logic [ITEM_WIDTH-1:0]         next_w  [DEPTH];
  logic [DEPTH-1:0]              match_w;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  // The output register can take a new result when it is empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign apply_fire = (state_q == S_APPLY) && out_free;

  assign is_search = (op_i == ole_pkg::OP_REMOVE_VAL) || (op_i == ole_pkg::OP_FIND);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = is_search ? S_CMP : S_APPLY;
        end
      end
      S_CMP: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_res.done) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      if (apply_fire) begin
        len_q <= len_d;
      end
    end
  end

  // The operation word is captured once and held until the result is loaded.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_i;
      idx_q <= index_i;
      val_q <= ITEM_WIDTH'(value_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Operation decode: status, new length and the command for the cell chain.
  // ---------------------------------------------------------------------------
  assign idx_ext = CW'(idx_q);
  assign len_ext = CW'(len_q);
  assign full    = (len_q == LW'(DEPTH));

  always_comb begin
    status_d = ole_pkg::ST_OK;
    found_d  = 1'b0;
    pos_res  = '0;
    len_d    = len_q;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    cell_pos = PW'(idx_q);
    case (op_q)
      ole_pkg::OP_APPEND: begin
        if (full) begin
          status_d = ole_pkg::ST_FULL;
        end else begin
          // An append is an insert at the tail.
          cell_pos = PW'(len_q);
          do_ins   = 1'b1;
          len_d    = len_q + LW'(1);
        end
      end
      ole_pkg::OP_INSERT: begin
        if (idx_ext > len_ext) begin
          status_d = ole_pkg::ST_RANGE;
        end else if (full) begin
          status_d = ole_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
          len_d  = len_q + LW'(1);
        end
      end
      ole_pkg::OP_REMOVE_AT: begin
        if (idx_ext >= len_ext) begin
          status_d = ole_pkg::ST_RANGE;
        end else begin
          do_del = 1'b1;
          len_d  = len_q - LW'(1);
        end
      end
      ole_pkg::OP_REMOVE_VAL, ole_pkg::OP_FIND: begin
        if (scan_res.hit) begin
          found_d  = 1'b1;
          pos_res  = scan_pos;
          cell_pos = scan_pos;
          if (op_q == ole_pkg::OP_REMOVE_VAL) begin
            do_del = 1'b1;
            len_d  = len_q - LW'(1);
          end
        end else begin
          status_d = ole_pkg::ST_NOTFOUND;
        end
      end
      ole_pkg::OP_CLEAR: begin
        len_d = '0;
      end
      default: begin
        // Unused codes change nothing and report success.
      end
    endcase
  end

  assign cmd.cmp = (state_q == S_CMP);
  assign cmd.ins = apply_fire && do_ins;
  assign cmd.del = apply_fire && do_del;

  // ---------------------------------------------------------------------------
  // Cell chain: cell g holds list position g.
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_w[g] = val_q;
    end else begin : g_body
      assign prev_w[g] = entry_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign next_w[g] = entry_w[g];
    end else begin : g_inner
      assign next_w[g] = entry_w[g+1];
    end

    ole_cell #(
      .DEPTH      (DEPTH),
      .ITEM_WIDTH (ITEM_WIDTH),
      .IDX        (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .pos_i   (cell_pos),
      .len_i   (len_q),
      .val_i   (val_q),
      .prev_i  (prev_w[g]),
      .next_i  (next_w[g]),
      .entry_o (entry_w[g]),
      .match_o (match_w[g])
    );
  end

  // ---------------------------------------------------------------------------
  // First-match search, started while the cells register their match flags.
  // ---------------------------------------------------------------------------
  ole_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd.cmp),
    .len_i   (len_q),
    .match_i (match_w),
    .res_o   (scan_res),
    .pos_o   (scan_pos)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (apply_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_fire) begin
      status_q   <= status_d;
      found_q    <= found_d;
      position_q <= ole_pkg::POS_W'(pos_res);
      count_q    <= ole_pkg::COUNT_W'(len_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign found_o     = found_q;
  assign position_o  = position_q;
  assign count_o     = count_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(DEPTH))
    else $error("list length exceeds the cell count");

  a_len_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !apply_fire |=> $stable(len_q))
    else $error("list length changed outside the apply step");

  a_shift_only_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.ins || cmd.del) |-> (state_q == S_APPLY) && out_free && !(cmd.ins && cmd.del))
    else $error("cell chain shifted outside a single apply step");

  a_notfound_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (found_o || status_o == ole_pkg::ST_NOTFOUND)
      |-> (found_o != (status_o == ole_pkg::ST_NOTFOUND))
       && (found_o || position_o == '0))
    else $error("found flag, status and position disagree");

endmodule
